[design/tsr_pkg.sv]
// tsr_pkg: shared types, constants and one's-complement helpers for the
// syn cookie reply rewriter; no dependencies
package tsr_pkg;

    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_ISN_HASH_MASK    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_WINDOW_SCALE     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_TIMESTAMP_ENABLE = 2'd2;

    localparam logic [31:0] HASH_MASK_RESET  = 32'h00FF_FFFF;
    localparam logic [5:0]  WSCALE_RESET     = 6'd7;
    localparam logic        TS_ENABLE_RESET  = 1'b1;

    localparam logic        ACT_SYN          = 1'b0;
    localparam logic [7:0]  FLAGS_SYNACK     = 8'h12;
    localparam logic [7:0]  FLAGS_ACK        = 8'h10;
    localparam logic [31:0] COOKIE_TIME_BITS = 32'h3F00_0000;
    localparam int unsigned MSS_CODE_SHIFT   = 30;
    localparam int unsigned TS_SHIFT         = 6;

    localparam logic [15:0] MSS_LVL3 = 16'd1460;
    localparam logic [15:0] MSS_LVL2 = 16'd1440;
    localparam logic [15:0] MSS_LVL1 = 16'd1300;
    localparam logic [1:0]  MSS_CODE3 = 2'h3;
    localparam logic [1:0]  MSS_CODE2 = 2'h2;
    localparam logic [1:0]  MSS_CODE1 = 2'h1;
    localparam logic [1:0]  MSS_CODE0 = 2'h0;

    // rewritten header fields travelling down the pipe
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [31:0] tsv;
        logic [31:0] tse;
    } reply_t;

    // 32-bit one's-complement add with end-around carry
    function automatic logic [31:0] oc_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[31:0] + {31'b0, s[32]};
    endfunction

    // fold a 32-bit one's-complement sum down to 16 bits
    function automatic logic [15:0] oc_fold16(input logic [31:0] s);
        logic [16:0] r;
        r = {1'b0, s[31:16]} + {1'b0, s[15:0]};
        return r[15:0] + {15'b0, r[16]};
    endfunction

    function automatic logic [1:0] mss_code(input logic present, input logic [15:0] mss);
        logic [1:0] c;
        if (!present)             c = MSS_CODE0;
        else if (mss >= MSS_LVL3) c = MSS_CODE3;
        else if (mss >= MSS_LVL2) c = MSS_CODE2;
        else if (mss >= MSS_LVL1) c = MSS_CODE1;
        else                      c = MSS_CODE0;
        return c;
    endfunction

endpackage

[design/tcp_syncookie_reply_rewriter_core.sv]
// tcp_syncookie_reply_rewriter_core: builds the reply tcp header (syn cookie
// syn-ack or final ack) and updates its checksum incrementally; uses tsr_pkg
//
// pipe: four pipe stages plus the output register; throughput: one beat
//   per cycle while m_ready does not stall the output, set by the adder
//   tree that is cut into one 32-bit add level per stage
// reset: aresetn synchronous active low; clears all stage valids and loads
//   the configuration registers with their defaults
module tcp_syncookie_reply_rewriter_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [tsr_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [31:0]                    cfg_wdata,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [31:0]                    s_in_seq,
    input  logic [31:0]                    s_in_ack,
    input  logic [7:0]                     s_in_flags,
    input  logic [15:0]                    s_in_checksum,
    input  logic [31:0]                    s_ts_value_in,
    input  logic [31:0]                    s_ts_echo_in,
    input  logic                           s_mss_present,
    input  logic [15:0]                    s_mss_value,
    input  logic [31:0]                    s_flow_hash,
    input  logic [31:0]                    s_time_high,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_out_seq,
    output logic [31:0]                    m_out_ack,
    output logic [7:0]                     m_out_flags,
    output logic [31:0]                    m_ts_value_out,
    output logic [31:0]                    m_ts_echo_out,
    output logic [15:0]                    m_out_checksum
);
    import tsr_pkg::*;

    // configuration registers
    logic [31:0] hash_mask_reg;
    logic [5:0]  wscale_reg;
    logic        ts_en_reg;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;

    // per-stage load enables: a stage loads when empty or when the next one loads
    logic ld1, ld2, ld3, ld4, ldo;

    // header fields per stage
    reply_t hdr1_reg, hdr2_reg, hdr3_reg, hdr4_reg, hdro_reg;
    reply_t hdr1_next;

    // checksum terms
    logic [31:0] nseq1_reg, nack1_reg, ncf1_reg, nts1_reg;
    logic        tsen1_reg;
    logic [31:0] a2_reg, b2_reg, c2_reg, d2_reg;
    logic [31:0] e3_reg, f3_reg;
    logic [31:0] acc4_reg;
    logic [15:0] csum_reg;

    logic [31:0] cookie;

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_mask_reg <= HASH_MASK_RESET;
            wscale_reg    <= WSCALE_RESET;
            ts_en_reg     <= TS_ENABLE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ISN_HASH_MASK:    hash_mask_reg <= cfg_wdata;
                CFG_WINDOW_SCALE:     wscale_reg    <= cfg_wdata[5:0];
                CFG_TIMESTAMP_ENABLE: ts_en_reg     <= cfg_wdata[0];
                default: ; // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // flow control: ready ripples back from the output register
    // ---------------------------------------------------------------------
    assign ldo     = !vo_reg || m_ready;
    assign ld4     = !v4_reg || ldo;
    assign ld3     = !v3_reg || ld4;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign s_ready = ld1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ldo) vo_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 1: new header fields and the cookie
    // ---------------------------------------------------------------------
    // cookie: mss code on top, six time bits, then the masked hash ored over all
    assign cookie = ({30'b0, mss_code(s_mss_present, s_mss_value)} << MSS_CODE_SHIFT)
                  | (s_time_high & COOKIE_TIME_BITS)
                  | (s_flow_hash & hash_mask_reg);

    always_comb begin
        hdr1_next.seq   = (s_action == ACT_SYN) ? cookie : s_in_ack;
        hdr1_next.flags = (s_action == ACT_SYN) ? FLAGS_SYNACK : FLAGS_ACK;
        hdr1_next.ack   = s_in_seq + 32'd1;
        if (ts_en_reg) begin
            hdr1_next.tse = s_ts_value_in;
            hdr1_next.tsv = (s_time_high << TS_SHIFT) | {26'b0, wscale_reg};
        end else begin
            hdr1_next.tse = s_ts_echo_in;
            hdr1_next.tsv = s_ts_value_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            hdr1_reg    <= hdr1_next;
            nseq1_reg   <= ~s_in_seq;
            nack1_reg   <= ~s_in_ack;
            // old checksum and old flags only depend on inputs, so join them here
            ncf1_reg    <= oc_add({16'hFFFF, ~s_in_checksum}, {24'hFF_FFFF, ~s_in_flags});
            nts1_reg    <= ~s_ts_echo_in;
            tsen1_reg   <= ts_en_reg;
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: first level of the one's-complement tree
    // end-around-carry sums are order independent, so pairs may be regrouped
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ld2) begin
            hdr2_reg <= hdr1_reg;
            a2_reg   <= oc_add(nseq1_reg, hdr1_reg.seq);
            b2_reg   <= oc_add(nack1_reg, hdr1_reg.ack);
            c2_reg   <= oc_add(ncf1_reg, {24'b0, hdr1_reg.flags});
            // a zero term is neutral, so disabled timestamps just drop out
            d2_reg   <= tsen1_reg ? oc_add(nts1_reg, hdr1_reg.tsv) : 32'd0;
        end
    end

    // stage 3: second level
    always_ff @(posedge aclk) begin
        if (ld3) begin
            hdr3_reg <= hdr2_reg;
            e3_reg   <= oc_add(a2_reg, b2_reg);
            f3_reg   <= oc_add(c2_reg, d2_reg);
        end
    end

    // stage 4: last level of the tree
    always_ff @(posedge aclk) begin
        if (ld4) begin
            hdr4_reg <= hdr3_reg;
            acc4_reg <= oc_add(e3_reg, f3_reg);
        end
    end

    // output register: fold to 16 bits and complement
    always_ff @(posedge aclk) begin
        if (ldo) begin
            hdro_reg <= hdr4_reg;
            csum_reg <= ~oc_fold16(acc4_reg);
        end
    end

    assign m_valid        = vo_reg;
    assign m_out_seq      = hdro_reg.seq;
    assign m_out_ack      = hdro_reg.ack;
    assign m_out_flags    = hdro_reg.flags;
    assign m_ts_value_out = hdro_reg.tsv;
    assign m_ts_echo_out  = hdro_reg.tse;
    assign m_out_checksum = csum_reg;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    // input only stalls when every stage holds a beat
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && vo_reg))
        else $error("input stalled with a bubble in the pipe");

    // an accepted beat lands in stage one
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted beat lost at stage one");

    // a full stage that cannot move keeps its beat
    a_stage4_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !ldo) |=> (v4_reg && $stable(acc4_reg)))
        else $error("stage four beat dropped during stall");

    // reply flags are always syn-ack or ack
    a_flags_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_flags == FLAGS_SYNACK || m_out_flags == FLAGS_ACK))
        else $error("illegal reply flags");

endmodule
